[design/cfd_pkg.sv]
// Shared constants for the command frame deframer.
package cfd_pkg;

    // Frame geometry.
    localparam int unsigned PayloadBytesDefault = 17;
    localparam int unsigned PayloadBytesMin     = 5;
    localparam int unsigned PayloadBytesMax     = 31;

    // Configuration port geometry.
    localparam int unsigned ApbAddrW = 3;
    localparam int unsigned ApbDataW = 32;

    // Register indexes, taken from paddr[2].
    localparam logic RegHeaderFirst  = 1'b0;
    localparam logic RegHeaderSecond = 1'b1;

    // Register reset values.
    localparam logic [7:0] HeaderFirstReset  = 8'h63;
    localparam logic [7:0] HeaderSecondReset = 8'h73;

endpackage

[design/command_frame_deframer_top.sv]
// Command frame deframer: header hunt, payload capture and additive checksum.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------------------
//  input    | i_in_valid   | o_in_stall   | i_rx_byte
//  output   | o_out_valid  | i_out_stall  | o_checksum_ok, o_route_yaw,
//           |              |              | o_route_distance, o_control_status
//  config   | psel/penable | pready (= 1) | paddr, pwrite, pwdata, prdata
//
// Every received byte is handled in the cycle it is accepted, so one byte per cycle
// is taken unless the input is stalled; the frame result is registered and appears in the
// cycle after the checksum byte is accepted. A frame is PAYLOAD_BYTES + 3 bytes long.
// i_rst_n is synchronous and active low; it restores the header bytes and starts hunting.
// Input is stalled only when a checksum byte arrives while an earlier result is still
// held by a stalled output; all other bytes are taken regardless of the output side.
module command_frame_deframer_top
    import cfd_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = PayloadBytesDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,

    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [7:0]          i_rx_byte,

    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic                o_checksum_ok,
    output logic [15:0]         o_route_yaw,
    output logic [15:0]         o_route_distance,
    output logic [7:0]          o_control_status,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ApbAddrW-1:0] paddr,
    input  logic [ApbDataW-1:0] pwdata,
    output logic [ApbDataW-1:0] prdata,
    output logic                pready
);

    localparam int unsigned IdxW = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(PAYLOAD_BYTES - 1);

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_PAYLOAD,
        PH_CHECK
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [IdxW-1:0] r_idx, n_idx;
    logic [7:0]      r_sum, n_sum;
    logic [15:0]     r_yaw, n_yaw;
    logic [15:0]     r_dist, n_dist;
    logic [7:0]      r_status, n_status;
    logic [7:0]      r_hdr_first, r_hdr_second;

    logic            r_out_valid;
    logic            r_out_ok;
    logic [15:0]     r_out_yaw;
    logic [15:0]     r_out_dist;
    logic [7:0]      r_out_status;

    logic            in_accept;
    logic            cfg_write;
    logic            emit;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            RegHeaderFirst:  prdata = {{(ApbDataW-8){1'b0}}, r_hdr_first};
            RegHeaderSecond: prdata = {{(ApbDataW-8){1'b0}}, r_hdr_second};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= HeaderFirstReset;
            r_hdr_second <= HeaderSecondReset;
        end else if (cfg_write) begin
            if (paddr[2] == RegHeaderFirst) begin
                r_hdr_first <= pwdata[7:0];
            end else begin
                r_hdr_second <= pwdata[7:0];
            end
        end
    end

    // Only the checksum byte needs room in the result register.
    assign o_in_stall = (r_phase == PH_CHECK) && r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign emit       = in_accept && (r_phase == PH_CHECK);

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_sum    = r_sum;
        n_yaw    = r_yaw;
        n_dist   = r_dist;
        n_status = r_status;
        unique case (r_phase)
            PH_FIRST: begin
                if (i_rx_byte == r_hdr_first) begin
                    n_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                priority if (i_rx_byte == r_hdr_second) begin
                    n_phase = PH_PAYLOAD;
                    n_idx   = '0;
                    n_sum   = '0;
                end else if (i_rx_byte == r_hdr_first) begin
                    n_phase = PH_SECOND;
                end else begin
                    n_phase = PH_FIRST;
                end
            end
            PH_PAYLOAD: begin
                n_sum = r_sum + i_rx_byte;
                if (r_idx == IdxW'(0)) n_yaw[15:8]  = i_rx_byte;
                if (r_idx == IdxW'(1)) n_yaw[7:0]   = i_rx_byte;
                if (r_idx == IdxW'(2)) n_dist[15:8] = i_rx_byte;
                if (r_idx == IdxW'(3)) n_dist[7:0]  = i_rx_byte;
                if (r_idx == IdxW'(4)) n_status     = i_rx_byte;
                if (r_idx == LastIdx) begin
                    n_phase = PH_CHECK;
                end else begin
                    n_idx = r_idx + IdxW'(1);
                end
            end
            PH_CHECK: begin
                n_phase = PH_FIRST;
                n_idx   = '0;
            end
            default: n_phase = PH_FIRST;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FIRST;
            r_idx       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_sum   <= n_sum;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Frame fields and the result register carry no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_yaw    <= n_yaw;
            r_dist   <= n_dist;
            r_status <= n_status;
        end
        if (emit) begin
            r_out_ok     <= (i_rx_byte == r_sum);
            r_out_yaw    <= r_yaw;
            r_out_dist   <= r_dist;
            r_out_status <= r_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_checksum_ok    = r_out_ok;
    assign o_route_yaw      = r_out_yaw;
    assign o_route_distance = r_out_dist;
    assign o_control_status = r_out_status;

    a_stall_only_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_phase == PH_CHECK && r_out_valid))
        else $error("input stalled outside the checksum byte");

    a_check_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |=> (r_out_valid && r_phase == PH_FIRST))
        else $error("checksum byte did not produce a result");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LastIdx)
        else $error("payload index out of range");

    a_payload_ends_in_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_phase == PH_PAYLOAD && r_idx == LastIdx) |=> r_phase == PH_CHECK)
        else $error("payload end did not move to checksum");

endmodule

[dv/tb_command_frame_deframer_top.sv]
// Self-checking testbench for the command frame deframer: header hunt, payload capture, checksum.
module tb_command_frame_deframer_top;
    import cfd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PayloadLen = PayloadBytesDefault;

    typedef enum logic [1:0] {
        HuntFirst  = 2'd0,
        HuntSecond = 2'd1,
        Collect    = 2'd2,
        AwaitSum   = 2'd3
    } t_hunt_state;

    typedef struct packed {
        logic        ok;
        logic [15:0] yaw;
        logic [15:0] distance;
        logic [7:0]  status;
    } t_frame_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [7:0]          i_rx_byte;
    logic                o_out_valid;
    logic                i_out_stall;
    logic                o_checksum_ok;
    logic [15:0]         o_route_yaw;
    logic [15:0]         o_route_distance;
    logic [7:0]          o_control_status;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ApbAddrW-1:0] paddr;
    logic [ApbDataW-1:0] pwdata;
    logic [ApbDataW-1:0] prdata;
    logic                pready;

    // Predicted block state and header registers.
    logic [7:0]    hdr_first_q  = HeaderFirstReset;
    logic [7:0]    hdr_second_q = HeaderSecondReset;
    t_hunt_state   hunt_st      = HuntFirst;
    logic [4:0]    pay_idx      = '0;
    logic [7:0]    pay_sum      = '0;
    logic [15:0]   yaw_acc      = '0;
    logic [15:0]   dist_acc     = '0;
    logic [7:0]    stat_acc     = '0;

    t_frame_result frames_due[$];
    int            mismatch_cnt = 0;
    int            bytes_sent   = 0;
    int            burst_left   = 0;
    bit            gaps_on      = 1'b0;
    int            stall_level  = 0;

    command_frame_deframer_top #(
        .PAYLOAD_BYTES(PayloadLen)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_rx_byte       (i_rx_byte),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_checksum_ok   (o_checksum_ok),
        .o_route_yaw     (o_route_yaw),
        .o_route_distance(o_route_distance),
        .o_control_status(o_control_status),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Output stall pattern: windows of random length, each either quiet or busy.
    initial begin
        int win_left;
        bit win_busy;
        win_left = 0;
        win_busy = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (win_left == 0) begin
                win_left = $urandom_range(1, 32);
                win_busy = ($urandom_range(0, 99) < stall_level * 25);
            end
            win_left--;
            i_out_stall <= win_busy && ($urandom_range(0, 3) != 0);
        end
    end

    // Advances the predicted deframer by one accepted byte.
    task automatic deframe_predict(input logic [7:0] b);
        t_frame_result r;
        case (hunt_st)
            HuntFirst: begin
                if (b == hdr_first_q) hunt_st = HuntSecond;
            end
            HuntSecond: begin
                if (b == hdr_second_q) begin
                    hunt_st  = Collect;
                    pay_idx  = '0;
                    pay_sum  = '0;
                    yaw_acc  = '0;
                    dist_acc = '0;
                    stat_acc = '0;
                end else if (b == hdr_first_q) begin
                    hunt_st = HuntSecond;
                end else begin
                    hunt_st = HuntFirst;
                end
            end
            Collect: begin
                pay_sum = pay_sum + b;
                case (pay_idx)
                    5'd0: yaw_acc[15:8]  = b;
                    5'd1: yaw_acc[7:0]   = b;
                    5'd2: dist_acc[15:8] = b;
                    5'd3: dist_acc[7:0]  = b;
                    5'd4: stat_acc       = b;
                    default: ;
                endcase
                pay_idx = pay_idx + 5'd1;
                if (pay_idx >= PayloadLen) hunt_st = AwaitSum;
            end
            default: begin
                r.ok       = (b == pay_sum);
                r.yaw      = yaw_acc;
                r.distance = dist_acc;
                r.status   = stat_acc;
                frames_due.push_back(r);
                hunt_st = HuntFirst;
                pay_idx = '0;
            end
        endcase
    endtask

    // Sends one byte, starting just after the clock rises; returns once the byte is accepted.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (gaps_on && burst_left == 0) begin
            i_in_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (o_in_stall);
        deframe_predict(b);
        bytes_sent++;
    endtask

    // Stops input and waits until every predicted frame result has come out.
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic idx, input logic [7:0] val);
        logic [31:0] junk;
        junk    = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ApbAddrW'({idx, 2'b00});
        pwdata  <= ApbDataW'({junk[31:8], val});
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == RegHeaderFirst) hdr_first_q = val;
        else hdr_second_q = val;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_check(input logic idx);
        logic [7:0] want;
        want    = (idx == RegHeaderFirst) ? hdr_first_q : hdr_second_q;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ApbAddrW'({idx, 2'b00});
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== ApbDataW'(want)) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("register %0d read: expected %h, got %h", idx, want, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_headers(input logic [7:0] first, input logic [7:0] second);
        settle_idle();
        reg_write(RegHeaderFirst, first);
        reg_write(RegHeaderSecond, second);
        reg_check(RegHeaderFirst);
        reg_check(RegHeaderSecond);
    endtask

    // One complete frame with the current headers; corrupt spoils the checksum byte.
    task automatic send_frame(input bit corrupt);
        logic [7:0] body[PayloadLen];
        logic [7:0] sum;
        int         flavor;
        sum    = '0;
        flavor = $urandom_range(0, 7);
        for (int i = 0; i < PayloadLen; i++) begin
            if (flavor == 0) body[i] = 8'h00;
            else if (flavor == 1) body[i] = 8'hFF;
            else body[i] = 8'($urandom());
            sum = sum + body[i];
        end
        send_byte(hdr_first_q);
        send_byte(hdr_second_q);
        foreach (body[i]) send_byte(body[i]);
        if (corrupt) send_byte(sum ^ 8'($urandom_range(1, 255)));
        else send_byte(sum);
    endtask

    // Mostly well-formed frames, with bad checksums, noise, broken headers and cut-off frames mixed in.
    task automatic gen_traffic(input int n);
        int start;
        int kind;
        int cnt;
        start = bytes_sent;
        while (bytes_sent - start < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                send_frame(1'b0);
            end else if (kind < 80) begin
                send_frame(1'b1);
            end else if (kind < 88) begin
                cnt = $urandom_range(1, 6);
                repeat (cnt) begin
                    if ($urandom_range(0, 3) == 0) send_byte(hdr_first_q);
                    else send_byte(8'($urandom()));
                end
            end else if (kind < 95) begin
                cnt = $urandom_range(1, 3);
                repeat (cnt) send_byte(hdr_first_q);
                if ($urandom_range(0, 1) == 0) send_byte(hdr_second_q);
                else send_byte(8'($urandom()));
            end else begin
                send_byte(hdr_first_q);
                send_byte(hdr_second_q);
                cnt = $urandom_range(0, PayloadLen - 1);
                repeat (cnt) send_byte(8'($urandom()));
            end
        end
    endtask

    task automatic test_reset_values();
        reg_check(RegHeaderFirst);
        reg_check(RegHeaderSecond);
    endtask

    // Header mismatch and repeated first byte, then a frame of extreme field values.
    task automatic test_directed_frames();
        logic [7:0] sum;
        sum = '0;
        send_byte(hdr_second_q);
        send_byte(hdr_first_q);
        send_byte(8'h00);
        send_byte(hdr_first_q);
        send_byte(hdr_first_q);
        send_byte(hdr_second_q);
        for (int i = 0; i < PayloadLen; i++) begin
            if (i == 0 || i == 1 || i == 4) begin
                send_byte(8'hFF);
                sum = sum + 8'hFF;
            end else begin
                send_byte(8'h00);
            end
        end
        send_byte(sum);
        settle_idle();
    endtask

    // New header values written in the middle of a frame only matter for the next hunt.
    task automatic test_midframe_write();
        send_byte(hdr_first_q);
        send_byte(hdr_second_q);
        repeat (8) send_byte(8'($urandom()));
        set_headers(8'h5A, 8'hA5);
        repeat (PayloadLen - 8) send_byte(8'($urandom()));
        send_byte(8'($urandom()));
        send_frame(1'b0);
        send_frame(1'b1);
        settle_idle();
    endtask

    task automatic test_header_settings();
        logic [7:0] firsts[6];
        logic [7:0] seconds[6];
        firsts  = '{HeaderFirstReset, 8'h00, 8'hFF, 8'hAA, 8'h00, 8'($urandom())};
        seconds = '{HeaderSecondReset, 8'hFF, 8'h00, 8'hAA, 8'h00, 8'($urandom())};
        for (int p = 0; p < 6; p++) begin
            set_headers(firsts[p], seconds[p]);
            gaps_on     = (p != 0) && (p != 3);
            stall_level = (p == 0) ? 0 : (p % 4) + 1;
            gen_traffic(330);
        end
        settle_idle();
        stall_level = 0;
    endtask

    // Compares every accepted frame result with the oldest prediction.
    always @(posedge i_clk) begin : frame_check
        t_frame_result got;
        t_frame_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_checksum_ok, o_route_yaw, o_route_distance, o_control_status};
            if (frames_due.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected frame result: ok=%b yaw=%h dist=%h status=%h",
                             got.ok, got.yaw, got.distance, got.status);
            end else begin
                want = frames_due.pop_front();
                if (got !== want) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display({"frame mismatch: expected ok=%b yaw=%h dist=%h status=%h,",
                                  " got ok=%b yaw=%h dist=%h status=%h"},
                                 want.ok, want.yaw, want.distance, want.status,
                                 got.ok, got.yaw, got.distance, got.status);
                end
            end
        end
    end

    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_rx_byte  <= 8'h00;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed_frames();
        test_midframe_write();
        test_header_settings();

        settle_idle();
        repeat (5) @(posedge i_clk);
        if (frames_due.size() != 0)
            $display("frame results never seen: %0d", frames_due.size());
        if (mismatch_cnt == 0 && frames_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
